### hdl/dq_pkg.sv
// Shared types, sizes and ring-index helpers for the double-ended queue.
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_W       = ((OP_W + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W  = STATUS_W + 2 * VALUE_BITS + 1 + CNT_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_HEAD,
    S_RD_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    val_t wdata;
    logic re;
    idx_t raddr;
  } ram_req_t;

  typedef struct packed {
    cnt_t    count;
    logic    empty;
    val_t    back;
    val_t    front;
    status_t status;
  } res_t;

  // a + b modulo DEPTH, with a < DEPTH and b <= DEPTH
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t ring_dec(idx_t a);
    return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
  endfunction

endpackage

### hdl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dq_ctrl.sv
// Head/count/direction state, operation decode and the read sequencer.
module dq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [dq_pkg::IN_W-1:0] in_tdata,
  input  dq_pkg::val_t           ram_rdata,
  output dq_pkg::ram_req_t       ram_req,
  input  logic                   res_free,
  output logic                   res_load,
  output dq_pkg::res_t           res
);
  import dq_pkg::*;

  state_t  state_r, state_nxt;
  idx_t    head_r, head_nxt;
  cnt_t    count_r, count_nxt;
  logic    rev_r, rev_nxt;
  status_t status_r, status_nxt;
  val_t    head_val_r;

  op_t  op;
  val_t val;
  logic accept;
  logic full;
  logic at_head;
  logic do_write;
  idx_t wr_addr;

  assign op     = op_t'(in_tdata[OP_W-1:0]);
  assign val    = in_tdata[OP_W +: VALUE_BITS];
  assign accept = in_tvalid && in_tready;
  assign full   = (count_r == CNT_W'(DEPTH));

  // next-state decode of the queue pointers
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = status_r;
    at_head    = 1'b0;
    do_write   = 1'b0;
    wr_addr    = ring_add(head_r, count_r);
    if (accept) begin
      status_nxt = ST_OK;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          at_head = (op == OP_PUSH_FRONT) ^ rev_r;
          if (full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            do_write  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (at_head) begin
              wr_addr  = ring_dec(head_r);
              head_nxt = ring_dec(head_r);
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          at_head = (op == OP_POP_FRONT) ^ rev_r;
          if (count_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            if (at_head) begin
              head_nxt = ring_add(head_r, CNT_W'(1));
            end
          end
        end
        OP_REVERSE: rev_nxt = ~rev_r;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_RD_HEAD;
      S_RD_HEAD: state_nxt = S_RD_TAIL;
      S_RD_TAIL: state_nxt = S_DONE;
      S_DONE:    if (res_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = 1'b0;
    res_load      = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = wr_addr;
    ram_req.wdata = val;
    ram_req.re    = 1'b0;
    ram_req.raddr = head_r;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        ram_req.we = accept && do_write;
      end
      S_RD_HEAD: ram_req.re = 1'b1;
      S_RD_TAIL: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ring_add(head_r, count_r - CNT_W'(1));
      end
      S_DONE: res_load = res_free;
      default: ;
    endcase
  end

  // tail data sits on the RAM output in S_DONE; it holds while no read is issued
  always_comb begin
    res.status = status_r;
    res.count  = count_r;
    res.empty  = (count_r == '0);
    if (count_r == '0) begin
      res.front = '0;
      res.back  = '0;
    end else if (rev_r) begin
      res.front = ram_rdata;
      res.back  = head_val_r;
    end else begin
      res.front = head_val_r;
      res.back  = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      rev_r    <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rev_r    <= rev_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD_TAIL) begin
      head_val_r <= ram_rdata;
    end
  end

endmodule

### hdl/deque_with_reverse.sv
// Top level of the double-ended queue with constant-time reverse.
//
// Input channel in_*: one operation per item (push back, push front,
// pop front, pop back, reverse) with the value to push. Output channel
// out_*: one result per operation with status, front and back values,
// empty flag and entry count after the operation.
//
// Entries live in a 16-entry ring RAM; head index, count and direction
// flag live in registers. Each item passes through the accept step
// (pointer update and RAM write for a push), a head-slot read, a
// tail-slot read, and loading of the output register. The single RAM
// read port sets this sequence; a new item is accepted only after the
// last one has loaded the output register. The result shows on
// out_tvalid once the item has passed S_RD_HEAD, S_RD_TAIL and S_DONE.
//
// The output register lets the next item be accepted while a result
// waits. If the receiver stalls, the following item stops in its last
// step until the output register is free, and in_tready stays low.
// Reset empties the queue and clears reverse; no RAM clearing is needed.
module deque_with_reverse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [2:0] opcode, [34:3] push_value, rest zero
  input  logic [dq_pkg::IN_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [1:0] status, [33:2] front_value, [65:34] back_value,
  // [66] empty_flag, [71:67] entry_count
  output logic [dq_pkg::OUT_W-1:0] out_tdata
);
  import dq_pkg::*;

  ram_req_t ram_req;
  val_t     ram_rdata;
  logic     res_free;
  logic     res_load;
  res_t     res;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  dq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res)
  );

  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_res_r);

endmodule

### bench/dq_checker.sv
// Checker for the deque: tracks its own copy of the deque and compares every result.
module dq_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [dq_pkg::IN_W-1:0]  in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [dq_pkg::OUT_W-1:0] out_tdata,
  output int                       err_count,
  output int                       pending
);
  import dq_pkg::*;

  val_t slots [DEPTH];
  idx_t head;
  cnt_t held;
  logic rev;

  res_t expected_results [$];

  initial err_count = 0;
  initial pending = 0;

  task automatic report_mismatch(input string msg);
    $display("deque mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Applies one operation to the tracked deque and returns the result it produces.
  function automatic res_t apply_deque_op(input logic [OP_W-1:0] op, input val_t v);
    res_t r;
    logic at_head;
    val_t hv;
    val_t tv;
    r = '0;
    r.status = ST_OK;
    hv = '0;
    tv = '0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held >= cnt_t'(DEPTH)) begin
          r.status = ST_OVERFLOW;
        end else begin
          at_head = (op == OP_PUSH_FRONT) != rev;
          if (at_head) begin
            head = head - idx_t'(1);
            slots[head] = v;
          end else begin
            slots[head + idx_t'(held)] = v;
          end
          held = held + cnt_t'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          at_head = (op == OP_POP_FRONT) != rev;
          if (at_head) head = head + idx_t'(1);
          held = held - cnt_t'(1);
        end
      end
      OP_REVERSE: rev = ~rev;
      default: ;
    endcase
    if (held != '0) begin
      hv = slots[head];
      tv = slots[head + idx_t'(held - cnt_t'(1))];
    end
    r.front = rev ? tv : hv;
    r.back  = rev ? hv : tv;
    r.empty = (held == '0);
    r.count = held;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      head <= '0;
      held <= '0;
      rev  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_deque_op(in_tdata[OP_W-1:0],
                                                  in_tdata[OP_W +: VALUE_BITS]));
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.front !== want.front)
            report_mismatch($sformatf("front %h, expected %h", got.front, want.front));
          if (got.back !== want.back)
            report_mismatch($sformatf("back %h, expected %h", got.back, want.back));
          if (got.empty !== want.empty)
            report_mismatch($sformatf("empty %b, expected %b", got.empty, want.empty));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

### bench/tb.sv
// Testbench top: drives deque operations under varied flow control and reports the verdict.
module tb;
  import dq_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int err_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deque_with_reverse i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dq_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .err_count  (err_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Called right after a rising edge; returns right after the edge that accepts the item.
  task automatic send_op(input logic [OP_W-1:0] op, input val_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({v, op});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(input mode_t mode);
    int r;
    int push_pct;
    logic [OP_W-1:0] op;
    push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
    r = $urandom_range(0, 99);
    if (r < 2)
      op = OP_REVERSE + OP_W'($urandom_range(1, 3));   // opcodes past reverse do nothing
    else if (r < 10)
      op = OP_REVERSE;
    else if ($urandom_range(0, 99) < push_pct)
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    send_op(op, pick_value());
  endtask

  initial begin
    int idle_tab  [PHASES];
    int stall_tab [PHASES];
    int left;
    mode_t mode;
    idle_tab  = '{0, 79, 0, 6, 0};
    stall_tab = '{0, 0, 79, 6, 0};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque: reverse and pops on empty
    send_op(OP_REVERSE, '0);
    send_op(OP_POP_FRONT, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REVERSE, '0);
    // extremes at both ends
    send_op(OP_PUSH_BACK, {1'b1, {(VALUE_BITS-1){1'b0}}});
    send_op(OP_PUSH_FRONT, {1'b0, {(VALUE_BITS-1){1'b1}}});
    send_op(OP_PUSH_BACK, '1);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_REVERSE + OP_W'(1), '1);
    send_op(OP_REVERSE + OP_W'(2), '1);
    send_op(OP_REVERSE + OP_W'(3), '1);
    // reversed order: pushes and pops land on swapped ends
    send_op(OP_REVERSE, '0);
    send_op(OP_PUSH_BACK, 32'h5555_5555);
    send_op(OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REVERSE, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_all_results();
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      left = 0;
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (left == 0) begin
          mode = mode_t'($urandom_range(0, 2));
          left = $urandom_range(8, 40);
        end
        left--;
        if ($urandom_range(0, 99) == 0) wait_all_results();
        send_random(mode);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### deque_with_reverse.f
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/deque_with_reverse.sv
bench/dq_checker.sv
bench/tb.sv
